[design/mbe_pkg.sv]
// Shared types, widths and helpers for the Mandelbrot escape-time block.
// No dependencies; every other design file uses this package by scoped names.
package mbe_pkg;

  // Fixed-point format: signed Q4.28
  localparam int Q_W       = 32;
  localparam int FRAC_BITS = 28;
  localparam int COL_W     = 12;
  localparam int ITER_W    = 16;

  // Coordinate clamp limit
  localparam int MAX_COLUMNS = 4096;

  // Column times step product and its sum with min_re
  localparam int PROD_W = COL_W + 1 + Q_W;
  localparam int SUM_W  = PROD_W + 1;

  // Wide intermediate width used by the saturation helper
  localparam int SAT_W = 48;

  // Width of the per-step sums (squares after shift fit in 35 bits)
  localparam int ZW = 40;

  // Escape threshold 4.0
  localparam logic signed [ZW-1:0] FOUR = ZW'(64'sd4 <<< FRAC_BITS);

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_RE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RE_STEP  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ITER = 2'd2;

  localparam logic signed [Q_W-1:0] MIN_RE_RST   = -32'sd536870912;
  localparam logic signed [Q_W-1:0] RE_STEP_RST  = 32'sd262144;
  localparam logic [ITER_W-1:0]     MAX_ITER_RST = 16'd255;

  // Queue between front and back
  localparam int Q_DEPTH = 2;
  localparam int Q_AW    = $clog2(Q_DEPTH);
  localparam int Q_CW    = $clog2(Q_DEPTH + 1);

  // One pixel ready for iteration
  typedef struct packed {
    logic signed [Q_W-1:0] c_re;
    logic signed [Q_W-1:0] c_imag;
    logic [COL_W-1:0]      column;
  } pixel_t;

  // Queue status
  typedef struct packed {
    logic [Q_CW-1:0] count;
  } q_status_t;

  // Back-end status
  typedef struct packed {
    logic busy;
  } bk_status_t;

  // Back-end states
  typedef enum logic [3:0] {
    BK_IDLE = 4'b0001,
    BK_MUL  = 4'b0010,
    BK_ADD  = 4'b0100,
    BK_DONE = 4'b1000
  } bk_state_e;

  // Saturate a wide signed value to the Q4.28 range
  function automatic logic signed [Q_W-1:0] sat_q(input logic signed [SAT_W-1:0] v);
    logic [SAT_W-Q_W:0] top;
    logic signed [Q_W-1:0] r;
    top = v[SAT_W-1:Q_W-1];
    if ((&top) || !(|top)) begin
      r = v[Q_W-1:0];
    end else if (v[SAT_W-1]) begin
      r = {1'b1, {(Q_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(Q_W-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

[design/mbe_in_if.sv]
// Input channel of the Mandelbrot escape-time block: one pixel request per item.
// Depends on mbe_pkg for field widths.
interface mbe_in_if;
  logic                           valid;
  logic                           ready;
  logic signed [mbe_pkg::Q_W-1:0] c_imag;
  logic [mbe_pkg::COL_W-1:0]      column;

  modport source(output valid, output c_imag, output column, input ready);
  modport sink(input valid, input c_imag, input column, output ready);
endinterface

[design/mbe_out_if.sv]
// Output channel of the Mandelbrot escape-time block: one result per item.
// Depends on mbe_pkg for field widths.
interface mbe_out_if;
  logic                         valid;
  logic                         ready;
  logic [mbe_pkg::COL_W-1:0]    out_column;
  logic [mbe_pkg::ITER_W-1:0]   iterations;

  modport source(output valid, output out_column, output iterations, input ready);
  modport sink(input valid, input out_column, input iterations, output ready);
endinterface

[design/mandelbrot_escape_time_top.sv]
// Mandelbrot escape-time kernel: each item (c_imag, column) returns one result
// (out_column, iterations). The front end forms c_re in a registered product stage
// and a registered sum stage and hands the pixel through a two-entry queue to the
// back end, which runs each complex step as a multiply state, then a
// sum/test/saturate state. The back end takes a new pixel only after the last one
// has left for the output register, so its iteration loop sets the rate, and the
// front end keeps accepting while the back end works, until the queue and its own
// stages are full. Configuration is written through cfg_we_i/cfg_idx_i/cfg_data_i:
// index 0 min_re, 1 re_step, 2 max_iterations; other indexes are ignored. Depends
// on mbe_pkg, the channel interfaces, mbe_front, mbe_queue and mbe_back.
module mandelbrot_escape_time_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  mbe_in_if.sink                            in_if,
  mbe_out_if.source                         out_if,
  input  logic                              cfg_we_i,
  input  logic [mbe_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [mbe_pkg::CFG_DATA_W-1:0]    cfg_data_i
);

  logic signed [mbe_pkg::Q_W-1:0]  min_re_q, re_step_q;
  logic [mbe_pkg::ITER_W-1:0]      max_iter_q;
  logic                            fr_valid, fr_ready, bk_valid, bk_ready;
  mbe_pkg::pixel_t                 fr_pix, bk_pix;
  mbe_pkg::q_status_t              q_status;
  mbe_pkg::bk_status_t             bk_status;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_re_q   <= mbe_pkg::MIN_RE_RST;
      re_step_q  <= mbe_pkg::RE_STEP_RST;
      max_iter_q <= mbe_pkg::MAX_ITER_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        mbe_pkg::CFG_MIN_RE:   min_re_q   <= cfg_data_i;
        mbe_pkg::CFG_RE_STEP:  re_step_q  <= cfg_data_i;
        mbe_pkg::CFG_MAX_ITER: max_iter_q <= cfg_data_i[mbe_pkg::ITER_W-1:0];
        default: ;
      endcase
    end
  end

  mbe_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_if       (in_if),
    .min_re_i    (min_re_q),
    .re_step_i   (re_step_q),
    .pix_valid_o (fr_valid),
    .pix_ready_i (fr_ready),
    .pix_o       (fr_pix)
  );

  mbe_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fr_valid),
    .push_ready_o (fr_ready),
    .push_data_i  (fr_pix),
    .pop_valid_o  (bk_valid),
    .pop_ready_i  (bk_ready),
    .pop_data_o   (bk_pix),
    .status_o     (q_status)
  );

  mbe_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pix_valid_i (bk_valid),
    .pix_ready_o (bk_ready),
    .pix_i       (bk_pix),
    .max_iter_i  (max_iter_q),
    .out_if      (out_if),
    .status_o    (bk_status)
  );

`ifndef SYNTH
  // Queue fill never exceeds its depth
  a_q_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_status.count <= mbe_pkg::Q_CW'(mbe_pkg::Q_DEPTH))
    else $error("queue count above depth");

  // The back end takes no new pixel while it is iterating
  a_no_pop_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bk_status.busy |-> !bk_ready)
    else $error("pixel taken while back end busy");

  // A new result only appears after the back end finished a pixel
  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_if.valid) |-> $past(bk_status.busy))
    else $error("result without iteration");
`endif

endmodule

[design/mbe_front.sv]
// Front end: accepts items and forms the real coordinate min_re + column * re_step.
// Two-stage valid/ready pipeline; depends on mbe_pkg and mbe_in_if.
module mbe_front (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  mbe_in_if.sink                         in_if,
  input  logic signed [mbe_pkg::Q_W-1:0] min_re_i,
  input  logic signed [mbe_pkg::Q_W-1:0] re_step_i,
  output logic                           pix_valid_o,
  input  logic                           pix_ready_i,
  output mbe_pkg::pixel_t                pix_o
);

  logic                                 s1_valid_q, s1_valid_d;
  logic signed [mbe_pkg::PROD_W-1:0]    s1_prod_q;
  logic signed [mbe_pkg::Q_W-1:0]       s1_im_q;
  logic [mbe_pkg::COL_W-1:0]            s1_col_q;
  logic                                 s2_valid_q, s2_valid_d;
  mbe_pkg::pixel_t                      s2_pix_q;
  logic                                 s1_free, s2_free, in_take, s1_move;
  logic [mbe_pkg::COL_W:0]              col_ext;
  logic [mbe_pkg::COL_W-1:0]            col_eff;
  logic signed [mbe_pkg::PROD_W-1:0]    prod;
  logic signed [mbe_pkg::SUM_W-1:0]     sum;

  // Pipeline flow control
  assign s2_free  = !s2_valid_q || pix_ready_i;
  assign s1_free  = !s1_valid_q || s2_free;
  assign in_if.ready = s1_free;
  assign in_take  = in_if.valid && s1_free;
  assign s1_move  = s1_valid_q && s2_free;

  // Column clamp and product with the step
  assign col_ext = {1'b0, in_if.column};
  assign col_eff = (col_ext >= (mbe_pkg::COL_W + 1)'(mbe_pkg::MAX_COLUMNS))
                   ? mbe_pkg::COL_W'(mbe_pkg::MAX_COLUMNS - 1) : in_if.column;
  assign prod    = $signed({1'b0, col_eff}) * re_step_i;

  // Add the origin; saturation happens on the way into stage 2
  assign sum = mbe_pkg::SUM_W'(min_re_i) + mbe_pkg::SUM_W'(s1_prod_q);

  always_comb begin
    s1_valid_d = s1_valid_q;
    s2_valid_d = s2_valid_q;
    if (s1_free) begin
      s1_valid_d = in_if.valid;
    end
    if (s2_free) begin
      s2_valid_d = s1_valid_q;
    end
  end

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
      s2_valid_q <= s2_valid_d;
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_prod_q <= prod;
      s1_im_q   <= in_if.c_imag;
      s1_col_q  <= in_if.column;
    end
    if (s1_move) begin
      s2_pix_q.c_re   <= mbe_pkg::sat_q(mbe_pkg::SAT_W'(sum));
      s2_pix_q.c_imag <= s1_im_q;
      s2_pix_q.column <= s1_col_q;
    end
  end

  assign pix_valid_o = s2_valid_q;
  assign pix_o       = s2_pix_q;

endmodule

[design/mbe_queue.sv]
// Short FIFO that decouples the coordinate front end from the iteration back end.
// Depends on mbe_pkg for the pixel type and depth.
module mbe_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_valid_i,
  output logic                push_ready_o,
  input  mbe_pkg::pixel_t     push_data_i,
  output logic                pop_valid_o,
  input  logic                pop_ready_i,
  output mbe_pkg::pixel_t     pop_data_o,
  output mbe_pkg::q_status_t  status_o
);

  mbe_pkg::pixel_t            mem_q [mbe_pkg::Q_DEPTH];
  logic [mbe_pkg::Q_AW-1:0]   wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [mbe_pkg::Q_CW-1:0]   cnt_q, cnt_d;
  logic                       push, pop;

  assign push_ready_o = cnt_q != mbe_pkg::Q_CW'(mbe_pkg::Q_DEPTH);
  assign pop_valid_o  = cnt_q != '0;
  assign push = push_valid_i && push_ready_o;
  assign pop  = pop_valid_o && pop_ready_i;
  assign pop_data_o = mem_q[rd_ptr_q];
  assign status_o.count = cnt_q;

  // Pointer and count update, wrapping at the depth
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == mbe_pkg::Q_AW'(mbe_pkg::Q_DEPTH - 1))
                 ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == mbe_pkg::Q_AW'(mbe_pkg::Q_DEPTH - 1))
                 ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

[design/mbe_back.sv]
// Back end: iterates z = z*z + c for one pixel, each step as a product state, then
// a state for sums, escape test and saturation. Depends on mbe_pkg, mbe_out_if.
module mbe_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        pix_valid_i,
  output logic                        pix_ready_o,
  input  mbe_pkg::pixel_t             pix_i,
  input  logic [mbe_pkg::ITER_W-1:0]  max_iter_i,
  mbe_out_if.source                   out_if,
  output mbe_pkg::bk_status_t         status_o
);

  mbe_pkg::bk_state_e                 state_q, state_d;
  mbe_pkg::pixel_t                    pix_q;
  logic signed [mbe_pkg::Q_W-1:0]     zr_q, zi_q;
  logic [mbe_pkg::ITER_W-1:0]         n_q;
  logic signed [2*mbe_pkg::Q_W-1:0]   rr_q, ii_q, ri_q;
  logic                               out_valid_q, out_valid_d;
  logic [mbe_pkg::COL_W-1:0]          out_col_q;
  logic [mbe_pkg::ITER_W-1:0]         out_iter_q;
  logic signed [mbe_pkg::ZW-1:0]      zr2, zi2, mag, cross_term, new_re, new_im;
  logic                               load, do_mul, do_step, escaped, finish, out_free;

  // Step arithmetic on registered products
  assign zr2    = mbe_pkg::ZW'(rr_q >>> mbe_pkg::FRAC_BITS);
  assign zi2    = mbe_pkg::ZW'(ii_q >>> mbe_pkg::FRAC_BITS);
  assign cross_term = mbe_pkg::ZW'(ri_q >>> (mbe_pkg::FRAC_BITS - 1));
  assign mag    = zr2 + zi2;
  assign escaped = mag > mbe_pkg::FOUR;
  assign new_re = zr2 - zi2 + mbe_pkg::ZW'(pix_q.c_re);
  assign new_im = cross_term + mbe_pkg::ZW'(pix_q.c_imag);

  assign out_free = !out_valid_q || out_if.ready;

  // Sequencer
  always_comb begin
    state_d     = state_q;
    load        = 1'b0;
    do_mul      = 1'b0;
    do_step     = 1'b0;
    finish      = 1'b0;
    pix_ready_o = 1'b0;
    unique case (state_q)
      mbe_pkg::BK_IDLE: begin
        pix_ready_o = 1'b1;
        if (pix_valid_i) begin
          load    = 1'b1;
          state_d = mbe_pkg::BK_MUL;
        end
      end
      mbe_pkg::BK_MUL: begin
        if (n_q == max_iter_i) begin
          state_d = mbe_pkg::BK_DONE;
        end else begin
          do_mul  = 1'b1;
          state_d = mbe_pkg::BK_ADD;
        end
      end
      mbe_pkg::BK_ADD: begin
        if (escaped) begin
          state_d = mbe_pkg::BK_DONE;
        end else begin
          do_step = 1'b1;
          state_d = mbe_pkg::BK_MUL;
        end
      end
      mbe_pkg::BK_DONE: begin
        if (out_free) begin
          finish  = 1'b1;
          state_d = mbe_pkg::BK_IDLE;
        end
      end
      default: begin
        state_d = mbe_pkg::BK_IDLE;
      end
    endcase
  end

  // Output register valid
  always_comb begin
    out_valid_d = out_valid_q;
    if (finish) begin
      out_valid_d = 1'b1;
    end else if (out_if.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mbe_pkg::BK_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Iteration datapath
  always_ff @(posedge clk_i) begin
    if (load) begin
      pix_q <= pix_i;
      zr_q  <= '0;
      zi_q  <= '0;
      n_q   <= '0;
    end
    if (do_mul) begin
      rr_q <= zr_q * zr_q;
      ii_q <= zi_q * zi_q;
      ri_q <= zr_q * zi_q;
    end
    if (do_step) begin
      zr_q <= mbe_pkg::sat_q(mbe_pkg::SAT_W'(new_re));
      zi_q <= mbe_pkg::sat_q(mbe_pkg::SAT_W'(new_im));
      n_q  <= n_q + 1'b1;
    end
    if (finish) begin
      out_col_q  <= pix_q.column;
      out_iter_q <= n_q;
    end
  end

  assign out_if.valid      = out_valid_q;
  assign out_if.out_column = out_col_q;
  assign out_if.iterations = out_iter_q;
  assign status_o.busy     = state_q != mbe_pkg::BK_IDLE;

endmodule

[tb/sv/testbench.sv]
// Self-checking testbench for mandelbrot_escape_time_top: directed pixel table, then
// random pixel phases under random configurations, checked against an in-bench predictor.
// Depends on mbe_pkg, mbe_in_if, mbe_out_if and the design files of the block.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned HOLD_OFF_CYCLES = 2000;
  localparam int unsigned STALL_LIMIT     = 400000;
  localparam longint      Q_HI            = 64'sd2147483647;
  localparam longint      Q_LO            = -64'sd2147483648;
  localparam longint      ESCAPE_Q        = 64'sd4 <<< mbe_pkg::FRAC_BITS;

  // One result of the block: echoed column and step count
  typedef struct {
    logic [mbe_pkg::COL_W-1:0]  column;
    logic [mbe_pkg::ITER_W-1:0] iterations;
  } px_result_t;

  typedef enum logic {ROW_PIXEL, ROW_CONFIG} row_kind_e;

  // Directed table row: a pixel (typed result optional) or a full register load
  typedef struct {
    row_kind_e                  kind;
    logic [mbe_pkg::Q_W-1:0]    c_imag;
    logic [mbe_pkg::COL_W-1:0]  column;
    bit                         typed;
    logic [mbe_pkg::ITER_W-1:0] iters;
    logic [mbe_pkg::Q_W-1:0]    min_re;
    logic [mbe_pkg::Q_W-1:0]    re_step;
    logic [31:0]                limit_word;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic                           cfg_we_i;
  logic [mbe_pkg::CFG_IDX_W-1:0]  cfg_idx_i;
  logic [mbe_pkg::CFG_DATA_W-1:0] cfg_data_i;

  mbe_in_if  in_ch ();
  mbe_out_if out_ch ();

  mandelbrot_escape_time_top i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_if      (in_ch),
    .out_if     (out_ch),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  // Local copy of the register file
  logic signed [mbe_pkg::Q_W-1:0] cfg_min_re     = mbe_pkg::MIN_RE_RST;
  logic signed [mbe_pkg::Q_W-1:0] cfg_re_step    = mbe_pkg::RE_STEP_RST;
  logic [mbe_pkg::ITER_W-1:0]     cfg_iter_limit = mbe_pkg::MAX_ITER_RST;

  px_result_t  inflight_px[$];
  stim_row_t   stim_table[$];
  int unsigned mismatches   = 0;
  int unsigned stall_cycles = 0;
  bit          steady_run   = 1'b0;
  bit          hold_off_req = 1'b0;

  always #5 clk_i = ~clk_i;

  // Clamp to the signed Q4.28 range
  function automatic longint clamp_q(input longint v);
    if (v > Q_HI) return Q_HI;
    if (v < Q_LO) return Q_LO;
    return v;
  endfunction

  // Escape-time count for one pixel under the current registers
  function automatic logic [mbe_pkg::ITER_W-1:0] escape_count(
      input logic [mbe_pkg::Q_W-1:0] c_im_bits, input logic [mbe_pkg::COL_W-1:0] col);
    longint c_re, c_im, zr, zi, zr_sq, zi_sq, cross_term;
    int unsigned steps;
    c_im  = longint'(signed'(c_im_bits));
    c_re  = clamp_q(longint'(cfg_min_re) + longint'(col) * longint'(cfg_re_step));
    zr    = 0;
    zi    = 0;
    steps = 0;
    while (steps < cfg_iter_limit) begin
      zr_sq = (zr * zr) >>> mbe_pkg::FRAC_BITS;
      zi_sq = (zi * zi) >>> mbe_pkg::FRAC_BITS;
      if (zr_sq + zi_sq > ESCAPE_Q) break;
      // 2*zr*zi in one shift
      cross_term = (zr * zi) >>> (mbe_pkg::FRAC_BITS - 1);
      zr    = clamp_q(zr_sq - zi_sq + c_re);
      zi    = clamp_q(cross_term + c_im);
      steps++;
    end
    return steps[mbe_pkg::ITER_W-1:0];
  endfunction

  // Idle length: mostly short, now and then long
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(30, 120);
  endfunction

  function automatic void add_pixel(input logic [mbe_pkg::Q_W-1:0] c_im,
                                    input logic [mbe_pkg::COL_W-1:0] col,
                                    input bit typed, input logic [mbe_pkg::ITER_W-1:0] iters);
    stim_row_t row;
    row            = '{kind: ROW_PIXEL, default: '0};
    row.kind       = ROW_PIXEL;
    row.c_imag     = c_im;
    row.column     = col;
    row.typed      = typed;
    row.iters      = iters;
    stim_table.push_back(row);
  endfunction

  function automatic void add_config(input logic [mbe_pkg::Q_W-1:0] min_re,
                                     input logic [mbe_pkg::Q_W-1:0] step,
                                     input logic [31:0] limit_word);
    stim_row_t row;
    row            = '{kind: ROW_CONFIG, default: '0};
    row.kind       = ROW_CONFIG;
    row.min_re     = min_re;
    row.re_step    = step;
    row.limit_word = limit_word;
    stim_table.push_back(row);
  endfunction

  function automatic void report_mismatch(input string what, input longint want,
                                          input longint got);
    mismatches++;
    if (mismatches <= 10)
      $display("[%0t] mismatch %s: expected %0d, got %0d", $realtime, what, want, got);
  endfunction

  // Stop offering and wait until every pixel in flight has come back
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (inflight_px.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // Write all three registers back to back, block idle
  task automatic load_config(input logic [mbe_pkg::Q_W-1:0] min_re,
                             input logic [mbe_pkg::Q_W-1:0] step,
                             input logic [31:0] limit_word);
    wait_idle();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= mbe_pkg::CFG_MIN_RE;
    cfg_data_i <= min_re;
    @(posedge clk_i);
    cfg_idx_i  <= mbe_pkg::CFG_RE_STEP;
    cfg_data_i <= step;
    @(posedge clk_i);
    cfg_idx_i  <= mbe_pkg::CFG_MAX_ITER;
    cfg_data_i <= limit_word;
    @(posedge clk_i);
    cfg_we_i       <= 1'b0;
    cfg_min_re     = min_re;
    cfg_re_step    = step;
    cfg_iter_limit = limit_word[mbe_pkg::ITER_W-1:0];
  endtask

  // Offer one pixel, wait for the handshake, queue its result
  task automatic send_pixel(input logic [mbe_pkg::Q_W-1:0] c_im,
                            input logic [mbe_pkg::COL_W-1:0] col,
                            input bit typed, input logic [mbe_pkg::ITER_W-1:0] typed_iters);
    int unsigned gap;
    px_result_t  res;
    gap = (steady_run || $urandom_range(0, 1) == 0) ? 0 : idle_len();
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid  <= 1'b1;
    in_ch.c_imag <= c_im;
    in_ch.column <= col;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    res.column     = col;
    res.iterations = typed ? typed_iters : escape_count(c_im, col);
    inflight_px.push_back(res);
  endtask

  // Directed table, then random phases
  initial begin : stimulus
    int unsigned n_items, limit;
    logic [mbe_pkg::Q_W-1:0] min_re, step, c_im;
    rst_ni       <= 1'b0;
    cfg_we_i     <= 1'b0;
    cfg_idx_i    <= mbe_pkg::CFG_MIN_RE;
    cfg_data_i   <= '0;
    in_ch.valid  <= 1'b0;
    in_ch.c_imag <= '0;
    in_ch.column <= '0;

    // Reset registers: c_re = -2 + column/1024
    add_pixel(32'h0000_0000, 12'd0,    1'b1, 16'd255);  // c = -2, bounded
    add_pixel(32'h0000_0000, 12'd2048, 1'b1, 16'd255);  // c = 0
    add_pixel(32'h7FFF_FFFF, 12'd2048, 1'b1, 16'd1);
    add_pixel(32'h8000_0000, 12'd4095, 1'b1, 16'd1);
    add_pixel(32'h0000_0000, 12'd4095, 1'b0, '0);
    add_pixel(32'h1000_0000, 12'd1536, 1'b0, '0);
    add_pixel(32'h0555_5555, 12'hAAA,  1'b0, '0);
    add_pixel(32'hFAAA_AAAB, 12'h555,  1'b0, '0);
    add_pixel(32'hFFFF_FFFF, 12'hFFF,  1'b0, '0);
    // Zero limit
    add_config(mbe_pkg::MIN_RE_RST, mbe_pkg::RE_STEP_RST, 32'h0000_0000);
    add_pixel(32'h0000_0000, 12'd2048, 1'b1, 16'd0);
    add_pixel(32'h7FFF_FFFF, 12'd4095, 1'b1, 16'd0);
    // Limit of one, upper data bits set
    add_config(mbe_pkg::MIN_RE_RST, mbe_pkg::RE_STEP_RST, 32'hA5A5_0001);
    add_pixel(32'h8000_0000, 12'd0,    1'b1, 16'd1);
    add_pixel(32'h0000_0000, 12'd2048, 1'b1, 16'd1);
    // Real coordinate saturating high, then low
    add_config(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0000_0008);
    add_pixel(32'h0000_0000, 12'd4095, 1'b1, 16'd1);
    add_pixel(32'h0000_0000, 12'd0,    1'b1, 16'd1);
    add_config(32'h8000_0000, 32'h8000_0000, 32'h0000_0008);
    add_pixel(32'h0000_0000, 12'd4095, 1'b1, 16'd1);
    add_pixel(32'h0000_0000, 12'd0,    1'b1, 16'd1);
    // Max plus min step lands next to zero
    add_config(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0014);
    add_pixel(32'h0000_0000, 12'd1,    1'b0, '0);
    // Largest limit: one pixel runs it out, one escapes at once
    add_config(32'h0000_0000, 32'h0000_0000, 32'h0000_FFFF);
    add_pixel(32'h0000_0000, 12'd0,    1'b1, 16'd65535);
    add_pixel(32'h7FFF_FFFF, 12'd4095, 1'b1, 16'd1);

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < stim_table.size(); i++) begin
      if (stim_table[i].kind == ROW_CONFIG) begin
        load_config(stim_table[i].min_re, stim_table[i].re_step, stim_table[i].limit_word);
      end else begin
        send_pixel(stim_table[i].c_imag, stim_table[i].column, stim_table[i].typed,
                   stim_table[i].iters);
      end
    end

    // Random phases: mostly the region of interest, some full-range values
    for (int ph = 0; ph < 8; ph++) begin
      n_items = (ph == 3) ? 100 : 220;
      if (ph == 0) limit = $urandom_range(1, 6);
      else if (ph == 3) limit = 255;
      else limit = $urandom_range(0, 40);
      min_re = ($urandom_range(0, 4) == 0) ? $urandom
                                           : $urandom_range(0, 32'h3000_0000) - 32'h2800_0000;
      step   = ($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(0, 32'h0004_0000);
      load_config(min_re, step, {16'($urandom), 16'(limit)});
      steady_run = (ph == 1 || ph == 5);
      // Output stalls long enough to back the block up into its input
      if (ph == 0) hold_off_req = 1'b1;
      for (int k = 0; k < n_items; k++) begin
        c_im = ($urandom_range(0, 3) == 0) ? $urandom
                                           : $urandom_range(0, 32'h4000_0000) - 32'h2000_0000;
        send_pixel(c_im, 12'($urandom_range(0, 4095)), 1'b0, '0);
      end
    end

    wait_idle();
    repeat (10) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Result side: random stalls, a long hold-off on request
  initial begin : result_sink
    out_ch.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk_i);
      end else if (!steady_run && $urandom_range(0, 3) == 0) begin
        out_ch.ready <= 1'b0;
        repeat (idle_len()) @(posedge clk_i);
      end else begin
        out_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
      end
    end
  end

  // Compare each returned item with the oldest pixel in flight
  always @(posedge clk_i) begin : result_check
    px_result_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (inflight_px.size() == 0) begin
        report_mismatch("unexpected item, column", -1, out_ch.out_column);
      end else begin
        want = inflight_px.pop_front();
        if (out_ch.out_column !== want.column)
          report_mismatch("out_column", want.column, out_ch.out_column);
        if (out_ch.iterations !== want.iterations)
          report_mismatch("iterations", want.iterations, out_ch.iterations);
      end
    end
  end

  // Watchdog on cycles without any handshake
  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

endmodule

[files.f]
design/mbe_pkg.sv
design/mbe_in_if.sv
design/mbe_out_if.sv
design/mbe_front.sv
design/mbe_queue.sv
design/mbe_back.sv
design/mandelbrot_escape_time_top.sv
tb/sv/testbench.sv
